[hdl/lowest_free_id_allocator_defines.svh]
// Assertion macros for the lowest-free id allocator checker.
// Depends on nothing; included by the checker file.
`ifndef LOWEST_FREE_ID_ALLOCATOR_DEFINES_SVH
`define LOWEST_FREE_ID_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LFID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LFID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/lfid_pkg.sv]
// Shared types and constants for the lowest-free id allocator.
// No dependencies; used by every module of the block.
package lfid_pkg;

   // default id space size
   localparam int DEFAULT_MAX_IDS = 1024;

   // bitmap memory word, and the summary slice searched per cycle
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;
   localparam int SCAN_W = 32;

   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_RELEASE = 2'd1,
      STATUS_EXHAUSTED   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_ALLOC,
      ST_REL,
      ST_COMPACT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;       // latch the request
      logic grow;          // grant the mark and raise it
      logic fail_exhaust;  // report no id available
      logic fail_release;  // report an out-of-range release
      logic scan;          // search one summary slice, read the hit word
      logic alloc;         // take lowest free bit of the read word
      logic rel_read;      // read the word of the released id
      logic rel_commit;    // mark the id free or flag a duplicate
      logic cmp_start;     // read the word just below the mark
      logic cmp_step;      // lower the mark through one word
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_release;
      logic has_free;
      logic full;
      logic rel_bad;
      logic rel_top;
      logic chunk_hit;
      logic cmp_done;
   } stat_type;

endpackage

[hdl/lowest_free_id_allocator.sv]
// Top level of the lowest-free id allocator.
// Depends on lfid_pkg, lfid_ctrl and lfid_datapath.
//
// Hands out ids 0..MAX_IDS-1, lowest returned id first, else the high-water
// mark, and takes them back; releasing the top id lowers the mark past all
// free ids beneath it. Raise start with the request while busy is low; the
// item is taken at that edge. The result is shown for one cycle with
// rsp_valid high and must be taken then: there is no way to hold it off.
// An acquire of a returned id searches the summary flags one 32-word slice
// per cycle; a top release walks the 32-bit bitmap words in compaction, one
// word per cycle through the single memory read port. The bitmap needs no
// clearing pass after reset: each word is zeroed as the mark first enters
// it, so the block is ready right out of reset.
module lowest_free_id_allocator #(
   parameter  int MAX_IDS = lfid_pkg::DEFAULT_MAX_IDS,
   localparam int ID_W    = $clog2(MAX_IDS),
   localparam int BOUND_W = $clog2(MAX_IDS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic [ID_W-1:0]    req_release_id,
   output logic               rsp_valid,
   output logic [ID_W-1:0]    rsp_granted_id,
   output logic [1:0]         rsp_status,
   output logic [BOUND_W-1:0] rsp_in_use_bound
);

   lfid_pkg::cmd_type  cmd;
   lfid_pkg::stat_type stat;

   lfid_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   lfid_datapath #(
      .MAX_IDS (MAX_IDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_release_id   (req_release_id),
      .rsp_valid        (rsp_valid),
      .rsp_granted_id   (rsp_granted_id),
      .rsp_status       (rsp_status),
      .rsp_in_use_bound (rsp_in_use_bound)
   );

endmodule

[hdl/lfid_ctrl.sv]
// Controller state machine for the lowest-free id allocator.
// Depends on lfid_pkg; drives the datapath through lfid_pkg::cmd_type.
module lfid_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  lfid_pkg::stat_type stat,
   output lfid_pkg::cmd_type  cmd
);

   lfid_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfid_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfid_pkg::ST_IDLE: begin
            if (start) state_in = lfid_pkg::ST_DISPATCH;
         end
         lfid_pkg::ST_DISPATCH: begin
            if (!stat.is_release) begin
               if (stat.has_free) state_in = lfid_pkg::ST_SCAN;
               else               state_in = lfid_pkg::ST_IDLE;
            end else if (stat.rel_bad) begin
               state_in = lfid_pkg::ST_IDLE;
            end else if (stat.rel_top) begin
               state_in = lfid_pkg::ST_COMPACT;
            end else begin
               state_in = lfid_pkg::ST_REL;
            end
         end
         lfid_pkg::ST_SCAN: begin
            if (stat.chunk_hit) state_in = lfid_pkg::ST_ALLOC;
         end
         lfid_pkg::ST_ALLOC: begin
            state_in = lfid_pkg::ST_IDLE;
         end
         lfid_pkg::ST_REL: begin
            state_in = lfid_pkg::ST_IDLE;
         end
         lfid_pkg::ST_COMPACT: begin
            if (stat.cmp_done) state_in = lfid_pkg::ST_IDLE;
         end
         default: begin
            state_in = lfid_pkg::ST_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         lfid_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         lfid_pkg::ST_DISPATCH: begin
            if (!stat.is_release) begin
               if (!stat.has_free) begin
                  if (stat.full) cmd.fail_exhaust = 1'b1;
                  else           cmd.grow         = 1'b1;
               end
            end else if (stat.rel_bad) begin
               cmd.fail_release = 1'b1;
            end else if (stat.rel_top) begin
               cmd.cmp_start = 1'b1;
            end else begin
               cmd.rel_read = 1'b1;
            end
         end
         lfid_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         lfid_pkg::ST_ALLOC: begin
            cmd.alloc = 1'b1;
         end
         lfid_pkg::ST_REL: begin
            cmd.rel_commit = 1'b1;
         end
         lfid_pkg::ST_COMPACT: begin
            cmd.cmp_step = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[hdl/lfid_datapath.sv]
// Datapath for the lowest-free id allocator: bitmap memory, per-word
// summary flags, high-water mark and result registers. Depends on lfid_pkg.
module lfid_datapath #(
   parameter  int MAX_IDS = lfid_pkg::DEFAULT_MAX_IDS,
   localparam int ID_W    = $clog2(MAX_IDS),
   localparam int BOUND_W = $clog2(MAX_IDS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  lfid_pkg::cmd_type  cmd,
   output lfid_pkg::stat_type stat,
   input  logic               req_operation,
   input  logic [ID_W-1:0]    req_release_id,
   output logic               rsp_valid,
   output logic [ID_W-1:0]    rsp_granted_id,
   output logic [1:0]         rsp_status,
   output logic [BOUND_W-1:0] rsp_in_use_bound
);

   localparam int WORD_W = lfid_pkg::WORD_W;
   localparam int BIT_W  = lfid_pkg::BIT_W;
   localparam int SCAN_W = lfid_pkg::SCAN_W;
   localparam int NWORDS = (MAX_IDS + WORD_W - 1) / WORD_W;
   localparam int NCHUNK = (NWORDS + SCAN_W - 1) / SCAN_W;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PADW   = AW + BIT_W;

   // request and state registers
   lfid_pkg::op_type     op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [BOUND_W-1:0]   mark_ff, mark_in;
   logic [NWORDS-1:0]    summary_ff, summary_in;
   logic [CW-1:0]        chunk_ff, chunk_in;
   logic [AW-1:0]        word_ff, word_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic                 first_ff, first_in;
   logic                 valid_ff, valid_in;
   logic [ID_W-1:0]      granted_ff, granted_in;
   lfid_pkg::status_type status_ff, status_in;

   // bitmap memory, one read and one write port
   logic [WORD_W-1:0]    mem [NWORDS];
   logic [WORD_W-1:0]    rd_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_W-1:0]    mem_wdata;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;

   // decoded values
   logic [PADW-1:0]      id_ext;
   logic [PADW-1:0]      mm1_ext;
   logic [PADW-1:0]      mark_ext;
   logic [BOUND_W-1:0]   mark_m1;
   logic [NCHUNK*SCAN_W-1:0] sum_pad;
   logic [SCAN_W-1:0]    chunk_bits;
   logic [BIT_W-1:0]     chunk_pos;
   logic [AW-1:0]        found_word;
   logic [BIT_W-1:0]     low_bit;
   logic [WORD_W-1:0]    le_mask;
   logic [WORD_W-1:0]    run_word;
   logic                 run_hit;
   logic [BIT_W-1:0]     run_pos;
   logic [WORD_W-1:0]    clr_mask;
   logic                 cmp_done;

   assign id_ext   = PADW'(id_ff);
   assign mark_m1  = mark_ff - BOUND_W'(1);
   assign mm1_ext  = PADW'(mark_m1);
   assign mark_ext = PADW'(mark_ff);

   // summary slice and its lowest flagged word
   always_comb begin
      sum_pad = '0;
      sum_pad[NWORDS-1:0] = summary_ff;
      chunk_bits = sum_pad[chunk_ff*SCAN_W +: SCAN_W];
      chunk_pos = '0;
      for (int i = SCAN_W - 1; i >= 0; i--) begin
         if (chunk_bits[i]) chunk_pos = BIT_W'(i);
      end
   end
   assign found_word = AW'({chunk_ff, chunk_pos});

   // lowest free bit in the read word
   always_comb begin
      low_bit = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (rd_ff[i]) low_bit = BIT_W'(i);
      end
   end

   // compaction: highest in-use bit at or below the cursor
   always_comb begin
      run_hit = 1'b0;
      run_pos = '0;
      for (int i = 0; i < WORD_W; i++) begin
         le_mask[i]  = (BIT_W'(i) <= bit_ff);
         run_word[i] = rd_ff[i] | (first_ff && (BIT_W'(i) == bit_ff));
         if (le_mask[i] && !run_word[i]) begin
            run_hit = 1'b1;
            run_pos = BIT_W'(i);
         end
      end
      for (int i = 0; i < WORD_W; i++) begin
         clr_mask[i] = le_mask[i] && (!run_hit || (BIT_W'(i) > run_pos));
      end
   end
   assign cmp_done = run_hit || (word_ff == '0);

   // status to controller
   always_comb begin
      stat.is_release = (op_ff == lfid_pkg::OP_RELEASE);
      stat.has_free   = |summary_ff;
      stat.full       = (mark_ff == BOUND_W'(MAX_IDS));
      stat.rel_bad    = (BOUND_W'(id_ff) >= mark_ff);
      stat.rel_top    = (BOUND_W'(id_ff) == mark_m1);
      stat.chunk_hit  = |chunk_bits;
      stat.cmp_done   = cmp_done;
   end

   // next-state logic per command
   always_comb begin
      op_in      = op_ff;
      id_in      = id_ff;
      mark_in    = mark_ff;
      summary_in = summary_ff;
      chunk_in   = chunk_ff;
      word_in    = word_ff;
      bit_in     = bit_ff;
      first_in   = first_ff;
      valid_in   = 1'b0;
      granted_in = granted_ff;
      status_in  = status_ff;
      mem_we     = 1'b0;
      mem_waddr  = word_ff;
      mem_wdata  = '0;
      rd_en      = 1'b0;
      rd_addr    = word_ff;

      if (cmd.capture) begin
         op_in    = lfid_pkg::op_type'(req_operation);
         id_in    = req_release_id;
         chunk_in = '0;
      end

      // acquire from the mark; a fresh word is zeroed as the mark enters it
      if (cmd.grow) begin
         granted_in = mark_ff[ID_W-1:0];
         status_in  = lfid_pkg::STATUS_OK;
         valid_in   = 1'b1;
         mark_in    = mark_ff + BOUND_W'(1);
         if (mark_ext[BIT_W-1:0] == '0) begin
            mem_we    = 1'b1;
            mem_waddr = mark_ext[PADW-1:BIT_W];
            mem_wdata = '0;
         end
      end

      if (cmd.fail_exhaust) begin
         granted_in = '0;
         status_in  = lfid_pkg::STATUS_EXHAUSTED;
         valid_in   = 1'b1;
      end

      if (cmd.fail_release) begin
         granted_in = '0;
         status_in  = lfid_pkg::STATUS_BAD_RELEASE;
         valid_in   = 1'b1;
      end

      // summary search, one slice per cycle
      if (cmd.scan) begin
         if (|chunk_bits) begin
            rd_en   = 1'b1;
            rd_addr = found_word;
            word_in = found_word;
         end else begin
            chunk_in = chunk_ff + CW'(1);
         end
      end

      // take the lowest free bit
      if (cmd.alloc) begin
         mem_we     = 1'b1;
         mem_waddr  = word_ff;
         mem_wdata  = rd_ff & ~(WORD_W'(1) << low_bit);
         summary_in[word_ff] = |mem_wdata;
         granted_in = ID_W'({word_ff, low_bit});
         status_in  = lfid_pkg::STATUS_OK;
         valid_in   = 1'b1;
      end

      if (cmd.rel_read) begin
         rd_en   = 1'b1;
         rd_addr = id_ext[PADW-1:BIT_W];
         word_in = id_ext[PADW-1:BIT_W];
         bit_in  = id_ext[BIT_W-1:0];
      end

      // free the id unless it is free already
      if (cmd.rel_commit) begin
         granted_in = '0;
         valid_in   = 1'b1;
         if (rd_ff[bit_ff]) begin
            status_in = lfid_pkg::STATUS_BAD_RELEASE;
         end else begin
            status_in  = lfid_pkg::STATUS_OK;
            mem_we     = 1'b1;
            mem_waddr  = word_ff;
            mem_wdata  = rd_ff | (WORD_W'(1) << bit_ff);
            summary_in[word_ff] = 1'b1;
         end
      end

      if (cmd.cmp_start) begin
         rd_en    = 1'b1;
         rd_addr  = mm1_ext[PADW-1:BIT_W];
         word_in  = mm1_ext[PADW-1:BIT_W];
         bit_in   = mm1_ext[BIT_W-1:0];
         first_in = 1'b1;
      end

      // lower the mark through one word, clearing the free run
      if (cmd.cmp_step) begin
         mem_we    = 1'b1;
         mem_waddr = word_ff;
         mem_wdata = rd_ff & ~clr_mask;
         summary_in[word_ff] = |mem_wdata;
         first_in  = 1'b0;
         if (run_hit) begin
            mark_in = BOUND_W'({word_ff, run_pos}) + BOUND_W'(1);
         end else begin
            mark_in = BOUND_W'({word_ff, {BIT_W{1'b0}}});
         end
         if (cmp_done) begin
            granted_in = '0;
            status_in  = lfid_pkg::STATUS_OK;
            valid_in   = 1'b1;
         end else begin
            rd_en   = 1'b1;
            rd_addr = word_ff - AW'(1);
            word_in = word_ff - AW'(1);
            bit_in  = '1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff    <= '0;
         summary_ff <= '0;
         chunk_ff   <= '0;
         first_ff   <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         mark_ff    <= mark_in;
         summary_ff <= summary_in;
         chunk_ff   <= chunk_in;
         first_ff   <= first_in;
         valid_ff   <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      id_ff      <= id_in;
      word_ff    <= word_in;
      bit_ff     <= bit_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
   end

   // bitmap memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (rd_en)  rd_ff <= mem[rd_addr];
   end

   assign rsp_valid        = valid_ff;
   assign rsp_granted_id   = granted_ff;
   assign rsp_status       = status_ff;
   assign rsp_in_use_bound = mark_ff;

endmodule

[hdl/lfid_checker.sv]
// Port-level assertions for the lowest-free id allocator, bound to the top.
// Depends on lfid_pkg and lowest_free_id_allocator_defines.svh.
`include "lowest_free_id_allocator_defines.svh"

module lfid_checker #(
   parameter  int MAX_IDS = lfid_pkg::DEFAULT_MAX_IDS,
   localparam int ID_W    = $clog2(MAX_IDS),
   localparam int BOUND_W = $clog2(MAX_IDS + 1)
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [ID_W-1:0]    rsp_granted_id,
   input logic [1:0]         rsp_status,
   input logic [BOUND_W-1:0] rsp_in_use_bound
);

   // an accepted item always raises busy in the cycle after it is taken
   `LFID_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted item did not raise busy")

   // results appear only once the block is free again
   `LFID_ASSERT_NOW(a_rsp_not_busy, clock, reset, rsp_valid, !busy, "result shown while busy")

   // one-cycle strobe: no item completes in two adjacent cycles
   `LFID_ASSERT_NEXT(a_rsp_strobe, clock, reset, rsp_valid, !rsp_valid, "result strobe held two cycles")

   // failed steps grant nothing
   `LFID_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && (rsp_status != lfid_pkg::STATUS_OK), rsp_granted_id == '0, "error result with nonzero id")

   // exhaustion only with the mark at the top of the id space
   `LFID_ASSERT_NOW(a_exhaust_full, clock, reset, rsp_valid && (rsp_status == lfid_pkg::STATUS_EXHAUSTED), rsp_in_use_bound == BOUND_W'(MAX_IDS), "exhausted below full mark")

endmodule

bind lowest_free_id_allocator lfid_checker #(
   .MAX_IDS (MAX_IDS)
) u_lfid_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_granted_id   (rsp_granted_id),
   .rsp_status       (rsp_status),
   .rsp_in_use_bound (rsp_in_use_bound)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for lowest_free_id_allocator: acquire and release items
// are checked against a bitmap-and-mark model kept inside the bench.
// Depends on lfid_pkg and the lowest_free_id_allocator RTL.
module tb_top;

   localparam int NUM_IDS     = lfid_pkg::DEFAULT_MAX_IDS;
   localparam int ID_W        = $clog2(NUM_IDS);
   localparam int BOUND_W     = $clog2(NUM_IDS + 1);
   localparam int IDLE_PCT    = 13;
   localparam int DRAIN_CYC   = 64;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      lfid_pkg::op_type op;
      logic [ID_W-1:0]  id;
   } id_request_type;

   typedef struct {
      logic [ID_W-1:0]      granted;
      lfid_pkg::status_type status;
      logic [BOUND_W-1:0]   bound;
   } id_grant_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_operation = lfid_pkg::OP_ACQUIRE;
   logic [ID_W-1:0]    req_release_id = '0;
   logic               rsp_valid;
   logic [ID_W-1:0]    rsp_granted_id;
   logic [1:0]         rsp_status;
   logic [BOUND_W-1:0] rsp_in_use_bound;

   // items waiting to be driven, and grants waiting to come back
   id_request_type request_q[$];
   id_grant_type   grant_q[$];

   // planning copy of the allocator state (stimulus side)
   logic [NUM_IDS-1:0] plan_free;
   logic [BOUND_W-1:0] plan_mark;
   // checking copy of the allocator state (updated at acceptance)
   logic [NUM_IDS-1:0] chk_free;
   logic [BOUND_W-1:0] chk_mark;

   logic           req_taken = 1'b0;
   id_request_type next_req;
   id_grant_type   exp_grant;
   id_grant_type   new_grant;
   int             items_sent = 0;
   int             items_taken = 0;
   int             grants_seen = 0;
   int             mismatches = 0;
   int             n_rejected = 0;
   int             n_exhausted = 0;
   int             peak_mark = 0;
   int             stall_cycles = 0;

   lowest_free_id_allocator #(.MAX_IDS(NUM_IDS)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_release_id   (req_release_id),
      .rsp_valid        (rsp_valid),
      .rsp_granted_id   (rsp_granted_id),
      .rsp_status       (rsp_status),
      .rsp_in_use_bound (rsp_in_use_bound)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // One allocator step: lowest returned id first, else grow the mark;
   // releasing the top id lowers the mark past every free id beneath it.
   function automatic void alloc_step(input lfid_pkg::op_type op,
                                      input logic [ID_W-1:0] id,
                                      inout logic [NUM_IDS-1:0] free_bits,
                                      inout logic [BOUND_W-1:0] mark,
                                      output id_grant_type res);
      int   i;
      logic found;
      res.granted = '0;
      res.status  = lfid_pkg::STATUS_OK;
      found       = 1'b0;
      if (op == lfid_pkg::OP_ACQUIRE) begin
         for (i = 0; i < int'(mark) && !found; i++) begin
            if (free_bits[i]) begin
               found        = 1'b1;
               free_bits[i] = 1'b0;
               res.granted  = ID_W'(i);
            end
         end
         if (!found) begin
            if (int'(mark) < NUM_IDS) begin
               res.granted = ID_W'(mark);
               mark        = mark + 1'b1;
            end else begin
               res.status = lfid_pkg::STATUS_EXHAUSTED;
            end
         end
      end else if ({1'b0, id} >= mark) begin
         res.status = lfid_pkg::STATUS_BAD_RELEASE;
      end else if ({1'b0, id} == mark - 1'b1) begin
         mark = mark - 1'b1;
         while (mark != 0 && free_bits[mark - 1'b1]) begin
            free_bits[mark - 1'b1] = 1'b0;
            mark = mark - 1'b1;
         end
      end else if (free_bits[id]) begin
         res.status = lfid_pkg::STATUS_BAD_RELEASE;
      end else begin
         free_bits[id] = 1'b1;
      end
      res.bound = mark;
   endfunction

   // queue one item and advance the planning state with it
   task automatic queue_item(input lfid_pkg::op_type op, input logic [ID_W-1:0] id);
      id_request_type item;
      id_grant_type   unused;
      item.op = op;
      item.id = id;
      request_q.push_back(item);
      alloc_step(op, id, plan_free, plan_mark, unused);
   endtask

   // acquire: the id field is ignored, so fill it with noise
   task automatic acq();
      queue_item(lfid_pkg::OP_ACQUIRE, ID_W'($urandom_range(NUM_IDS - 1)));
   endtask

   task automatic rel(input int id);
      queue_item(lfid_pkg::OP_RELEASE, ID_W'(id));
   endtask

   function automatic int held_count();
      return int'(plan_mark) - $countones(plan_free);
   endfunction

   // some id that is currently handed out; caller checks one exists
   function automatic int pick_held();
      int k;
      int cand;
      for (k = 0; k < 16; k++) begin
         cand = $urandom_range(int'(plan_mark) - 1);
         if (!plan_free[cand]) return cand;
      end
      cand = $urandom_range(int'(plan_mark) - 1);
      for (k = 0; k < int'(plan_mark); k++) begin
         if (!plan_free[(cand + k) % int'(plan_mark)])
            return (cand + k) % int'(plan_mark);
      end
      return 0;
   endfunction

   // mostly well-formed traffic: acquires, releases of held ids and of the
   // top id, plus some releases of arbitrary ids
   task automatic run_mix(input int n, input int acq_pct);
      int r;
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 10) begin
            rel($urandom_range(NUM_IDS - 1));
         end else if (r < 10 + acq_pct || held_count() == 0) begin
            acq();
         end else if (r < 18 + acq_pct) begin
            rel(int'(plan_mark) - 1);
         end else begin
            rel(pick_held());
         end
      end
   endtask

   // Driver: present a new item once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (request_q.size() > 0 &&
             !((items_sent < 300 || items_sent >= 550) &&
               $urandom_range(99) < IDLE_PCT)) begin
            next_req = request_q.pop_front();
            start          <= 1'b1;
            req_operation  <= next_req.op;
            req_release_id <= next_req.id;
            items_sent++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check each grant, then predict for a newly accepted item
   always @(posedge clock) begin
      req_taken <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            grants_seen++;
            if (grant_q.size() == 0) begin
               $display("%0t: unexpected result: granted_id %0d status %0d bound %0d",
                        $time, rsp_granted_id, rsp_status, rsp_in_use_bound);
               mismatches++;
            end else begin
               exp_grant = grant_q.pop_front();
               if (rsp_granted_id !== exp_grant.granted) begin
                  $display("%0t: granted_id mismatch: expected %0d, actual %0d",
                           $time, exp_grant.granted, rsp_granted_id);
                  mismatches++;
               end
               if (rsp_status !== exp_grant.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, exp_grant.status, rsp_status);
                  mismatches++;
               end
               if (rsp_in_use_bound !== exp_grant.bound) begin
                  $display("%0t: in_use_bound mismatch: expected %0d, actual %0d",
                           $time, exp_grant.bound, rsp_in_use_bound);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            alloc_step(lfid_pkg::op_type'(req_operation), req_release_id, chk_free,
                       chk_mark, new_grant);
            grant_q.push_back(new_grant);
            items_taken++;
            if (new_grant.status == lfid_pkg::STATUS_BAD_RELEASE) n_rejected++;
            if (new_grant.status == lfid_pkg::STATUS_EXHAUSTED) n_exhausted++;
            if (int'(new_grant.bound) > peak_mark) peak_mark = int'(new_grant.bound);
         end
      end
   end

   // Watchdog: too long without any handshake while work is outstanding
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid ||
          (request_q.size() == 0 && grant_q.size() == 0 && !start)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      plan_free = '0;
      plan_mark = '0;
      chk_free  = '0;
      chk_mark  = '0;

      // directed: empty-mark releases, reuse, duplicates, compaction to zero
      rel(0);
      rel(NUM_IDS - 1);
      repeat (4) acq();
      rel(1);
      rel(1);
      rel(4);
      rel(2);
      acq();
      rel(3);
      acq();
      rel(0);
      rel(2);
      rel(1);
      acq();
      rel(0);

      // random traffic from a low mark
      run_mix(200, 55);

      // push the mark up across many bitmap words
      repeat (300) acq();

      // free a band under the top, then release the top to compact it
      repeat (60) rel(int'(plan_mark) - 2 - $urandom_range(60));
      rel(0);
      rel(int'(plan_mark) / 2);
      rel(int'(plan_mark) / 2);
      rel(int'(plan_mark) - 1);
      rel(int'(plan_mark) - 1);
      repeat (3) acq();

      // random traffic from a high mark
      run_mix(160, 40);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_q.size() > 0 || start || grant_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);

      if (grant_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, grant_q.size());
         mismatches++;
      end
      $display("Covered %0d items and %0d results; %0d rejected releases,",
               items_taken, grants_seen, n_rejected);
      $display("%0d acquires with no id left, peak mark %0d; %0d mismatches.",
               n_exhausted, peak_mark, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
